// ===== design/priority_interrupt_controller_assert.svh =====
// Assertion macros shared by the controller blocks.
`ifndef PRIORITY_INTERRUPT_CONTROLLER_ASSERT_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
`define PIC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PIC_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);
`else
`define PIC_ASSERT(lbl, prop, msg)
`define PIC_ASSERT_NEXT(lbl, trig, cons, msg)
`endif

`endif

// ===== design/pic_pkg.sv =====
package pic_pkg;

	localparam logic [1:0] OP_EVENT = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [3:0] REG_TASK = 4'd9;
	localparam logic [3:0] REG_ACK  = 4'd10;
	localparam logic [3:0] REG_EOI  = 4'd11;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_MASKED  = 3'd1;
	localparam logic [2:0] ST_UNSUP   = 3'd2;
	localparam logic [2:0] ST_REFUSED = 3'd3;
	localparam logic [2:0] ST_BADREG  = 3'd4;

	localparam int MASK_BIT   = 31;
	localparam int ACTIVE_BIT = 30;
	localparam int PRI_LSB    = 16;
	localparam int PRI_MSB    = 19;

	localparam logic [31:0] CHANGE_MASK = 32'h000f_00ff;

	typedef struct packed {
		logic capture;
		logic apply;
		logic search;
		logic retire;
		logic deliver;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic needs_eval;
		logic is_eoi;
	} stat_t;

endpackage

// ===== design/priority_interrupt_controller.sv =====
// Sequencing, one item at a time: the item is captured and applied; a raised line event for an
// existing source then runs a search and a deliver step, and an end of interrupt runs search,
// retire, a second search and deliver; then the result is loaded into the output register.
// in_stall is high from acceptance until that load, and the load waits while out_stall holds the output.
// Reset (arst_n, asynchronous): all sources masked, nothing pending or in service,
// task priority 15, internal interrupt line low; int_request takes its value when a result is loaded.
module priority_interrupt_controller #(
	parameter int NUM_SOURCES = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [3:0]  source_id,
	input  logic        line_level,
	input  logic [3:0]  reg_select,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        int_request,
	output logic [2:0]  status
);
	import pic_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pic_datapath #(
		.NUM_SOURCES (NUM_SOURCES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (opcode),
		.source_id   (source_id),
		.line_level  (line_level),
		.reg_select  (reg_select),
		.write_data  (write_data),
		.read_data   (read_data),
		.int_request (int_request),
		.status      (status)
	);

endmodule

// ===== design/pic_ctrl.sv =====
`include "priority_interrupt_controller_assert.svh"

module pic_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  pic_pkg::stat_t stat,
	output pic_pkg::cmd_t  cmd
);
	import pic_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_APPLY   = 3'd1;
	localparam logic [2:0] S_SEARCH  = 3'd2;
	localparam logic [2:0] S_RETIRE  = 3'd3;
	localparam logic [2:0] S_DELIVER = 3'd4;
	localparam logic [2:0] S_DONE    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       eoi_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) state_d = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d = (stat.needs_eval || stat.is_eoi) ? S_SEARCH : S_DONE;
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				state_d = eoi_q ? S_RETIRE : S_DELIVER;
			end
			S_RETIRE: begin
				cmd.retire = 1'b1;
				state_d = S_SEARCH;
			end
			S_DELIVER: begin
				cmd.deliver = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.load_out = out_free;
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			eoi_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_APPLY) eoi_q <= stat.is_eoi;
			else if (state_q == S_RETIRE) eoi_q <= 1'b0;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	`PIC_ASSERT_NEXT(a_accept_apply, in_valid && !in_stall, state_q == S_APPLY, "item not applied")
	`PIC_ASSERT_NEXT(a_retire_once, state_q == S_RETIRE, state_q == S_SEARCH && !eoi_q, "retire loop")
	`PIC_ASSERT_NEXT(a_done_out, state_q == S_DONE && out_free, out_valid_q, "result lost")

endmodule

// ===== design/pic_datapath.sv =====
`include "priority_interrupt_controller_assert.svh"

module pic_datapath #(
	parameter int NUM_SOURCES = 9
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pic_pkg::cmd_t  cmd,
	output pic_pkg::stat_t stat,
	input  logic [1:0]     opcode,
	input  logic [3:0]     source_id,
	input  logic           line_level,
	input  logic [3:0]     reg_select,
	input  logic [31:0]    write_data,
	output logic [31:0]    read_data,
	output logic           int_request,
	output logic [2:0]     status
);
	import pic_pkg::*;

	localparam int IW = $clog2(NUM_SOURCES);
	localparam logic [4:0] NSRC = 5'(NUM_SOURCES);

	logic [1:0]  op_q;
	logic [3:0]  src_q;
	logic        lvl_q;
	logic [3:0]  reg_q;
	logic [31:0] data_q;

	logic [31:0]            vp_q [NUM_SOURCES];
	logic [NUM_SOURCES-1:0] pend_q;
	logic [NUM_SOURCES-1:0] insv_q;
	logic [3:0]             deliv_src_q;
	logic [7:0]             ack_vec_q;
	logic                   ack_out_q;
	logic [3:0]             task_q;
	logic                   line_q;

	logic [31:0] rd_q;
	logic [2:0]  st_q;

	logic [7:0]    best_vec_q;
	logic [3:0]    best_pri_q;
	logic [3:0]    best_idx_q;
	logic [3:0]    top_is_q;
	logic          sel_found_q;
	logic [IW-1:0] sel_idx_q;

	logic [3:0]    idx_full;
	logic          in_range;
	logic [IW-1:0] idx;
	logic [31:0]   word;
	logic          changes;
	logic          ack_in_range;
	logic [IW-1:0] ack_idx;

	logic [31:0] a_rd;
	logic [2:0]  a_st;
	logic        do_set;
	logic        do_vp;
	logic        do_task;
	logic        do_ack;

	logic [7:0]    s_vec;
	logic [3:0]    s_pri;
	logic [3:0]    s_idx;
	logic [3:0]    s_top;
	logic          s_found;
	logic [IW-1:0] s_sel;
	logic [3:0]    s_selp;
	logic          deliver_ok;

	assign idx_full     = (op_q == OP_EVENT) ? src_q : reg_q;
	assign in_range     = {1'b0, idx_full} < NSRC;
	assign idx          = idx_full[IW-1:0];
	assign word         = vp_q[idx];
	assign changes      = ((word ^ data_q) & CHANGE_MASK) != 32'd0;
	assign ack_in_range = {1'b0, deliv_src_q} < NSRC;
	assign ack_idx      = deliv_src_q[IW-1:0];

	always_comb begin
		a_rd = '0;
		a_st = ST_OK;
		do_set = 1'b0;
		do_vp = 1'b0;
		do_task = 1'b0;
		do_ack = 1'b0;
		stat = '0;
		case (op_q)
			OP_EVENT: begin
				if (lvl_q) begin
					if (!in_range) begin
						a_st = ST_UNSUP;
					end else begin
						stat.needs_eval = 1'b1;
						if (word[MASK_BIT]) a_st = ST_MASKED;
						else do_set = 1'b1;
					end
				end
			end
			OP_WRITE: begin
				if (reg_q == REG_TASK) begin
					do_task = 1'b1;
				end else if (reg_q == REG_EOI) begin
					stat.is_eoi = 1'b1;
				end else if (reg_q == REG_ACK) begin
					a_st = ST_BADREG;
				end else if (in_range) begin
					if (changes && word[ACTIVE_BIT]) a_st = ST_REFUSED;
					else do_vp = 1'b1;
				end else begin
					a_st = ST_BADREG;
				end
			end
			OP_READ: begin
				if (reg_q == REG_TASK) begin
					a_rd = {28'd0, task_q};
				end else if (reg_q == REG_ACK) begin
					a_rd = {24'd0, ack_vec_q};
					do_ack = 1'b1;
				end else if (reg_q == REG_EOI) begin
					a_rd = '0;
				end else if (in_range) begin
					a_rd = word;
				end else begin
					a_st = ST_BADREG;
				end
			end
			default: a_st = ST_BADREG;
		endcase
	end

	always_comb begin
		s_vec = '0;
		s_pri = '0;
		s_idx = '0;
		s_top = '0;
		s_found = 1'b0;
		s_sel = '0;
		s_selp = '0;
		for (int i = 0; i < NUM_SOURCES; i++) begin
			if (pend_q[i] && vp_q[i][PRI_MSB:PRI_LSB] > s_pri) begin
				s_pri = vp_q[i][PRI_MSB:PRI_LSB];
				s_vec = vp_q[i][7:0];
				s_idx = 4'(i);
			end
			if (insv_q[i]) begin
				if (vp_q[i][PRI_MSB:PRI_LSB] > s_top) s_top = vp_q[i][PRI_MSB:PRI_LSB];
				if (!s_found || vp_q[i][PRI_MSB:PRI_LSB] > s_selp) begin
					s_found = 1'b1;
					s_sel = IW'(i);
					s_selp = vp_q[i][PRI_MSB:PRI_LSB];
				end
			end
		end
	end

	assign deliver_ok = !ack_out_q && (task_q < best_pri_q) && (top_is_q < best_pri_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= opcode;
			src_q  <= source_id;
			lvl_q  <= line_level;
			reg_q  <= reg_select;
			data_q <= write_data;
		end
		if (cmd.apply) begin
			rd_q <= a_rd;
			st_q <= a_st;
		end
		if (cmd.search) begin
			best_vec_q  <= s_vec;
			best_pri_q  <= s_pri;
			best_idx_q  <= s_idx;
			top_is_q    <= s_top;
			sel_found_q <= s_found;
			sel_idx_q   <= s_sel;
		end
		if (cmd.load_out) begin
			read_data   <= rd_q;
			status      <= st_q;
			int_request <= line_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SOURCES; i++) vp_q[i] <= {1'b1, 31'd0};
			pend_q      <= '0;
			insv_q      <= '0;
			deliv_src_q <= '0;
			ack_vec_q   <= '0;
			ack_out_q   <= 1'b0;
			task_q      <= 4'hf;
			line_q      <= 1'b0;
		end else begin
			if (cmd.apply) begin
				if (do_set) begin
					pend_q[idx] <= 1'b1;
					vp_q[idx][ACTIVE_BIT] <= 1'b1;
				end
				if (do_vp) vp_q[idx] <= data_q;
				if (do_task) task_q <= data_q[3:0];
				if (do_ack && ack_out_q) begin
					if (ack_in_range && pend_q[ack_idx]) begin
						pend_q[ack_idx] <= 1'b0;
						insv_q[ack_idx] <= 1'b1;
						line_q <= 1'b0;
					end
					ack_out_q <= 1'b0;
				end
			end
			if (cmd.retire && sel_found_q) begin
				insv_q[sel_idx_q] <= 1'b0;
				if (!pend_q[sel_idx_q]) vp_q[sel_idx_q][ACTIVE_BIT] <= 1'b0;
			end
			if (cmd.deliver && deliver_ok) begin
				deliv_src_q <= best_idx_q;
				ack_vec_q   <= best_vec_q;
				line_q      <= 1'b1;
				ack_out_q   <= 1'b1;
			end
		end
	end

	`PIC_ASSERT(a_ack_line, ack_out_q |-> line_q, "acknowledge outstanding with line low")
	`PIC_ASSERT_NEXT(a_retire_drop, cmd.retire && sel_found_q, $countones(insv_q) == $past($countones(insv_q)) - 1, "retire kept source in service")
	`PIC_ASSERT_NEXT(a_deliver_set, cmd.deliver && deliver_ok, ack_out_q && line_q, "delivery not held")

endmodule

// ===== tb/pic_checker.sv =====
module pic_checker #(
	parameter int NUM_SOURCES = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [3:0]  source_id,
	input  logic        line_level,
	input  logic [3:0]  reg_select,
	input  logic [31:0] write_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] read_data,
	input  logic        int_request,
	input  logic [2:0]  status,
	output int          fail_count,
	output int          results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	import pic_pkg::*;

	typedef struct packed {
		logic [31:0] rd;
		logic        irq;
		logic [2:0]  st;
	} result_t;

	result_t     due_q[$];

	logic [31:0] vp_word[NUM_SOURCES];
	logic [15:0] pend;
	logic [15:0] insvc;
	logic [15:0] deliv;
	logic [7:0]  ack_vec;
	logic        ack_busy;
	logic [3:0]  task_pri;
	logic        line_up;

	initial begin
		fail_count = 0;
		results_due = 0;
	end

	function automatic logic [3:0] pri(int i);
		return vp_word[i][PRI_MSB:PRI_LSB];
	endfunction

	function automatic void clear_state();
		for (int i = 0; i < NUM_SOURCES; i++)
			vp_word[i] = 32'h8000_0000;
		pend = '0;
		insvc = '0;
		deliv = '0;
		ack_vec = '0;
		ack_busy = 1'b0;
		task_pri = 4'hf;
		line_up = 1'b0;
	endfunction

	function automatic void try_deliver();
		logic [3:0] best_p;
		logic [3:0] top_is;
		logic [7:0] best_v;
		int         best_i;
		if (ack_busy)
			return;
		best_p = '0;
		top_is = '0;
		best_v = '0;
		best_i = 0;
		for (int i = 0; i < NUM_SOURCES; i++) begin
			if (pend[i] && pri(i) > best_p) begin
				best_p = pri(i);
				best_v = vp_word[i][7:0];
				best_i = i;
			end
			if (insvc[i] && pri(i) > top_is)
				top_is = pri(i);
		end
		if (task_pri < best_p && top_is < best_p) begin
			deliv = {4'(best_i), best_p, best_v};
			ack_vec = best_v;
			line_up = 1'b1;
			ack_busy = 1'b1;
		end
	endfunction

	function automatic void retire_top();
		int         sel;
		logic [3:0] sel_p;
		sel = -1;
		sel_p = '0;
		for (int i = 0; i < NUM_SOURCES; i++) begin
			if (insvc[i] && (sel < 0 || pri(i) > sel_p)) begin
				sel = i;
				sel_p = pri(i);
			end
		end
		if (sel >= 0) begin
			insvc[sel] = 1'b0;
			if (!pend[sel])
				vp_word[sel][ACTIVE_BIT] = 1'b0;
		end
		try_deliver();
	endfunction

	function automatic logic [31:0] take_ack();
		logic [31:0] vec;
		logic [3:0]  src;
		vec = {24'b0, ack_vec};
		if (ack_busy) begin
			src = deliv[15:12];
			if (src < NUM_SOURCES && pend[src]) begin
				pend[src] = 1'b0;
				insvc[src] = 1'b1;
				line_up = 1'b0;
			end
			ack_busy = 1'b0;
		end
		return vec;
	endfunction

	function automatic result_t predict_item(logic [1:0] op, logic [3:0] src, logic lvl,
			logic [3:0] sel, logic [31:0] data);
		result_t     r;
		logic [31:0] old;
		r = '0;
		r.st = ST_OK;
		case (op)
			OP_EVENT: begin
				if (lvl) begin
					if (src >= NUM_SOURCES) begin
						r.st = ST_UNSUP;
					end else begin
						if (vp_word[src][MASK_BIT]) begin
							r.st = ST_MASKED;
						end else begin
							pend[src] = 1'b1;
							vp_word[src][ACTIVE_BIT] = 1'b1;
						end
						try_deliver();
					end
				end
			end
			OP_WRITE: begin
				if (sel == REG_TASK) begin
					task_pri = data[3:0];
				end else if (sel == REG_EOI) begin
					retire_top();
				end else if (sel == REG_ACK) begin
					r.st = ST_BADREG;
				end else if (sel < NUM_SOURCES) begin
					old = vp_word[sel];
					if (((old ^ data) & CHANGE_MASK) != 0 && old[ACTIVE_BIT])
						r.st = ST_REFUSED;
					else
						vp_word[sel] = data;
				end else begin
					r.st = ST_BADREG;
				end
			end
			OP_READ: begin
				if (sel == REG_TASK)
					r.rd = {28'b0, task_pri};
				else if (sel == REG_ACK)
					r.rd = take_ack();
				else if (sel == REG_EOI)
					r.rd = '0;
				else if (sel < NUM_SOURCES)
					r.rd = vp_word[sel];
				else
					r.st = ST_BADREG;
			end
			default: r.st = ST_BADREG;
		endcase
		r.irq = line_up;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_state();
			due_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (due_q.size() == 0) begin
					$display("%0t: unexpected item read_data %h int_request %b status %0d",
						$time, read_data, int_request, status);
					fail_count++;
				end else begin
					want = due_q.pop_front();
					check_field("read_data", want.rd, read_data);
					check_field("int_request", 32'(want.irq), 32'(int_request));
					check_field("status", 32'(want.st), 32'(status));
				end
			end
			if (in_valid && !in_stall)
				due_q.push_back(predict_item(opcode, source_id, line_level, reg_select,
					write_data));
		end
		results_due = due_q.size();
	end

endmodule

// ===== tb/priority_interrupt_controller_tb.sv =====
module priority_interrupt_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pic_pkg::*;

	localparam int         NUM_SRC   = 9;
	localparam int         NUM_ITEMS = 1300;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = '0;
	logic [3:0]  source_id = '0;
	logic        line_level = 1'b0;
	logic [3:0]  reg_select = '0;
	logic [31:0] write_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_data;
	logic        int_request;
	logic [2:0]  status;
	int          fail_count;
	int          results_due;
	bit          calm = 1'b0;

	priority_interrupt_controller #(.NUM_SOURCES(NUM_SRC)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.source_id(source_id),
		.line_level(line_level),
		.reg_select(reg_select),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.int_request(int_request),
		.status(status)
	);

	pic_checker #(.NUM_SOURCES(NUM_SRC)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.source_id(source_id),
		.line_level(line_level),
		.reg_select(reg_select),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.int_request(int_request),
		.status(status),
		.fail_count(fail_count),
		.results_due(results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_item(logic [1:0] op, logic [3:0] src, logic lvl, logic [3:0] sel,
			logic [31:0] data);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode = op;
		source_id = src;
		line_level = lvl;
		reg_select = sel;
		write_data = data;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random_item();
		int          kind;
		logic [1:0]  op;
		logic [3:0]  src;
		logic        lvl;
		logic [3:0]  sel;
		logic [31:0] data;
		kind = $urandom_range(0, 99);
		op = 2'($urandom_range(0, 3));
		src = 4'($urandom_range(0, 15));
		lvl = 1'($urandom_range(0, 1));
		sel = 4'($urandom_range(0, 15));
		data = $urandom;
		if (kind < 35) begin
			op = OP_EVENT;
			lvl = ($urandom_range(0, 9) != 0);
			if ($urandom_range(0, 9) != 0)
				src = 4'($urandom_range(0, NUM_SRC - 1));
		end else if (kind < 52) begin
			op = OP_WRITE;
			sel = 4'($urandom_range(0, NUM_SRC - 1));
			data[MASK_BIT] = ($urandom_range(0, 4) == 0);
			data[ACTIVE_BIT] = ($urandom_range(0, 9) == 0);
		end else if (kind < 57) begin
			op = OP_WRITE;
			sel = REG_TASK;
			if ($urandom_range(0, 3) != 0)
				data[3:0] = 4'($urandom_range(0, 3));
		end else if (kind < 77) begin
			op = OP_READ;
			sel = REG_ACK;
		end else if (kind < 92) begin
			op = OP_WRITE;
			sel = REG_EOI;
		end else if (kind < 97) begin
			op = OP_READ;
		end
		send_item(op, src, lvl, sel, data);
	endtask

	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			w = calm ? 0 : $urandom_range(0, 19);
			if (w > 0) begin
				out_stall = 1'b1;
				repeat (w) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_item(OP_READ, 4'd0, 1'b0, 4'd0, '0);
		send_item(OP_READ, 4'd0, 1'b0, REG_TASK, '0);
		send_item(OP_EVENT, 4'd0, 1'b1, 4'd0, '0);
		send_item(OP_EVENT, 4'd15, 1'b1, 4'd0, '0);
		send_item(OP_EVENT, 4'd3, 1'b0, 4'd0, '1);
		send_item(OP_WRITE, 4'd0, 1'b0, 4'd0, 32'h0005_0021);
		send_item(OP_WRITE, 4'd0, 1'b0, REG_TASK, 32'hffff_fff0);
		send_item(OP_EVENT, 4'd0, 1'b1, 4'd0, '0);
		send_item(OP_WRITE, 4'd0, 1'b0, 4'd0, 32'h0005_0022);
		send_item(OP_WRITE, 4'd0, 1'b0, 4'd0, 32'h4005_ff21);
		send_item(OP_READ, 4'd0, 1'b0, REG_ACK, '0);
		send_item(OP_READ, 4'd0, 1'b0, REG_ACK, '0);
		send_item(OP_WRITE, 4'd0, 1'b0, REG_ACK, '1);
		send_item(OP_WRITE, 4'd0, 1'b0, 4'd1, 32'h0000_00ff);
		send_item(OP_EVENT, 4'd1, 1'b1, 4'd0, '0);
		send_item(OP_WRITE, 4'd0, 1'b0, 4'd8, 32'h000f_00aa);
		send_item(OP_EVENT, 4'd8, 1'b1, 4'd0, '0);
		send_item(OP_READ, 4'd0, 1'b0, REG_ACK, '0);
		send_item(OP_EVENT, 4'd0, 1'b1, 4'd0, '0);
		send_item(OP_READ, 4'd0, 1'b0, REG_EOI, '0);
		send_item(OP_WRITE, 4'd0, 1'b0, REG_EOI, '1);
		send_item(OP_WRITE, 4'd0, 1'b0, REG_EOI, '0);
		send_item(OP_WRITE, 4'd0, 1'b0, 4'd13, '1);
		send_item(OP_READ, 4'd0, 1'b0, 4'd15, '0);
		send_item(OP_UNUSED, 4'd15, 1'b1, 4'd15, '1);
		send_item(OP_WRITE, 4'd0, 1'b0, 4'd7, '1);

		for (int n = 0; n < NUM_ITEMS; n++) begin
			if (n % 100 == 0)
				calm = ($urandom_range(0, 3) == 0);
			send_random_item();
		end
		in_valid = 1'b0;

		while (results_due != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
